### sv/trajectory_point_decimator_top_defines.svh
// Assertion macros for the trajectory point decimator checker.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef TRAJECTORY_POINT_DECIMATOR_TOP_DEFINES_SVH
`define TRAJECTORY_POINT_DECIMATOR_TOP_DEFINES_SVH

// Checked on every edge outside reset.
`define TRPD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define TRPD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### sv/trpd_pkg.sv
// Shared types and constants for the trajectory point decimator.
// No dependencies.
package trpd_pkg;

    localparam int MD_W = 16;
    localparam logic [MD_W-1:0] MD_RESET = 16'd66;

    typedef enum logic [1:0] {
        ACT_FIRST   = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_REPLACE = 2'd2,
        ACT_DROP    = 2'd3
    } t_action;

endpackage

### sv/trpd_close.sv
// Distance test: is the new point strictly closer than min_distance to the last one.
// Depends on trpd_pkg.
module trpd_close
    import trpd_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic signed [COORD_WIDTH-1:0] i_last_x,
    input  logic signed [COORD_WIDTH-1:0] i_last_y,
    input  logic signed [COORD_WIDTH-1:0] i_last_z,
    input  logic        [MD_W-1:0]        i_min_dist,
    output logic                          o_close
);

    localparam int DW = COORD_WIDTH + 1;

    logic signed [DW-1:0] dx, dy, dz;
    logic        [DW-1:0] ax, ay, az;
    logic        [DW-1:0] md_ext;
    logic                 any_far;
    logic [2*MD_W-1:0]    sq_x, sq_y, sq_z, md_sq;
    logic [2*MD_W+1:0]    sq_sum;

    always_comb begin
        dx = DW'(i_pos_x) - DW'(i_last_x);
        dy = DW'(i_pos_y) - DW'(i_last_y);
        dz = DW'(i_pos_z) - DW'(i_last_z);
        ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
        ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
        az = dz[DW-1] ? DW'(-dz) : DW'(dz);
        md_ext  = DW'(i_min_dist);
        any_far = (ax >= md_ext) || (ay >= md_ext) || (az >= md_ext);
        // past the per-axis check every magnitude fits in MD_W bits
        sq_x   = ax[MD_W-1:0] * ax[MD_W-1:0];
        sq_y   = ay[MD_W-1:0] * ay[MD_W-1:0];
        sq_z   = az[MD_W-1:0] * az[MD_W-1:0];
        md_sq  = i_min_dist * i_min_dist;
        sq_sum = (2*MD_W+2)'(sq_x) + (2*MD_W+2)'(sq_y) + (2*MD_W+2)'(sq_z);
        o_close = !any_far && (sq_sum < (2*MD_W+2)'(md_sq));
    end

endmodule

### sv/trajectory_point_decimator_top.sv
// Trajectory point decimator: keeps, replaces or drops tracked points by distance.
// Input register, then result and state register; one item per cycle unless the output stalls.
// Rate is set by the state loop: distance test, decision and box update are done together ahead of the state register.
// Synchronous active-low reset clears valids, the kept point, the box and have_point,
// and sets min_distance to 66.
// Depends on trpd_pkg and trpd_close.
module trajectory_point_decimator_top
    import trpd_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic        [MD_W-1:0]        i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic signed [COORD_WIDTH-1:0] i_pos_x,
    input  logic signed [COORD_WIDTH-1:0] i_pos_y,
    input  logic signed [COORD_WIDTH-1:0] i_pos_z,
    input  logic        [1:0]             i_confidence,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic        [1:0]             o_action,
    output logic signed [COORD_WIDTH-1:0] o_kept_x,
    output logic signed [COORD_WIDTH-1:0] o_kept_y,
    output logic signed [COORD_WIDTH-1:0] o_kept_z,
    output logic signed [COORD_WIDTH-1:0] o_box_min_x,
    output logic signed [COORD_WIDTH-1:0] o_box_min_y,
    output logic signed [COORD_WIDTH-1:0] o_box_min_z,
    output logic signed [COORD_WIDTH-1:0] o_box_max_x,
    output logic signed [COORD_WIDTH-1:0] o_box_max_y,
    output logic signed [COORD_WIDTH-1:0] o_box_max_z
);

    typedef logic signed [COORD_WIDTH-1:0] t_coord;

    logic [MD_W-1:0] r_min_dist;

    // input register
    logic       r_in_vld;
    t_coord     r_in_p [3];
    logic [1:0] r_in_conf;

    // kept state; it doubles as the result register
    logic       r_out_vld, n_out_vld;
    t_action    r_action, n_action;
    logic       r_have, n_have;
    t_coord     r_last [3];
    t_coord     n_last [3];
    logic [1:0] r_last_conf, n_last_conf;
    t_coord     r_lo [3];
    t_coord     n_lo [3];
    t_coord     r_hi [3];
    t_coord     n_hi [3];

    logic in_xfer, out_free, adv, close;

    assign out_free   = !r_out_vld || !i_out_stall;
    assign adv        = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    trpd_close #(.COORD_WIDTH(COORD_WIDTH)) u_close (
        .i_pos_x    (r_in_p[0]),
        .i_pos_y    (r_in_p[1]),
        .i_pos_z    (r_in_p[2]),
        .i_last_x   (r_last[0]),
        .i_last_y   (r_last[1]),
        .i_last_z   (r_last[2]),
        .i_min_dist (r_min_dist),
        .o_close    (close)
    );

    always_comb begin
        n_out_vld   = r_out_vld && i_out_stall;
        n_action    = r_action;
        n_have      = r_have;
        n_last      = r_last;
        n_last_conf = r_last_conf;
        n_lo        = r_lo;
        n_hi        = r_hi;
        if (adv) begin
            n_out_vld = 1'b1;
            if (!r_have) begin
                n_have      = 1'b1;
                n_action    = ACT_FIRST;
                n_last      = r_in_p;
                n_last_conf = r_in_conf;
                n_lo        = r_in_p;
                n_hi        = r_in_p;
            end else if (close && (r_in_conf <= r_last_conf)) begin
                n_action = ACT_DROP;
            end else begin
                n_action    = close ? ACT_REPLACE : ACT_APPEND;
                n_last      = r_in_p;
                n_last_conf = r_in_conf;
                for (int i = 0; i < 3; i++) begin
                    if (r_in_p[i] > r_hi[i]) n_hi[i] = r_in_p[i];
                    if (r_in_p[i] < r_lo[i]) n_lo[i] = r_in_p[i];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= MD_RESET;
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
            r_action    <= ACT_FIRST;
            r_have      <= 1'b0;
            r_last_conf <= 2'd0;
            for (int i = 0; i < 3; i++) begin
                r_last[i] <= '0;
                r_lo[i]   <= '0;
                r_hi[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) r_min_dist <= i_cfg_wdata;
            r_in_vld    <= in_xfer || (r_in_vld && !adv);
            r_out_vld   <= n_out_vld;
            r_action    <= n_action;
            r_have      <= n_have;
            r_last      <= n_last;
            r_last_conf <= n_last_conf;
            r_lo        <= n_lo;
            r_hi        <= n_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_p[0] <= i_pos_x;
            r_in_p[1] <= i_pos_y;
            r_in_p[2] <= i_pos_z;
            r_in_conf <= i_confidence;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_action    = r_action;
    assign o_kept_x    = r_last[0];
    assign o_kept_y    = r_last[1];
    assign o_kept_z    = r_last[2];
    assign o_box_min_x = r_lo[0];
    assign o_box_min_y = r_lo[1];
    assign o_box_min_z = r_lo[2];
    assign o_box_max_x = r_hi[0];
    assign o_box_max_y = r_hi[1];
    assign o_box_max_z = r_hi[2];

endmodule

### sv/trpd_checker.sv
// Port-level checks for trajectory_point_decimator_top, attached by bind.
// Depends on trpd_pkg and trajectory_point_decimator_top_defines.svh.
`include "trajectory_point_decimator_top_defines.svh"

module trpd_port_checker
    import trpd_pkg::*;
#(
    parameter int COORD_WIDTH = 32
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          o_in_stall,
    input logic                          o_out_valid,
    input logic                          i_out_stall,
    input logic        [1:0]             o_action,
    input logic signed [COORD_WIDTH-1:0] o_kept_x,
    input logic signed [COORD_WIDTH-1:0] o_kept_y,
    input logic signed [COORD_WIDTH-1:0] o_kept_z,
    input logic signed [COORD_WIDTH-1:0] o_box_min_x,
    input logic signed [COORD_WIDTH-1:0] o_box_min_y,
    input logic signed [COORD_WIDTH-1:0] o_box_min_z,
    input logic signed [COORD_WIDTH-1:0] o_box_max_x,
    input logic signed [COORD_WIDTH-1:0] o_box_max_y,
    input logic signed [COORD_WIDTH-1:0] o_box_max_z
);

    `TRPD_ASSERT_ALWAYS(a_rst_clears_out, !i_rst_n |=> !o_out_valid, "valid after reset")

    `TRPD_ASSERT(a_out_hold, o_out_valid && i_out_stall |=> o_out_valid && $stable(o_action) && $stable(o_kept_x) && $stable(o_box_max_z), "stalled transfer changed")

    // input side only backs up when a finished result is waiting
    `TRPD_ASSERT(a_stall_cause, o_in_stall |-> o_out_valid && i_out_stall, "stall without backlog")

    `TRPD_ASSERT(a_first_box, o_out_valid && o_action == ACT_FIRST |-> o_box_min_x == o_kept_x && o_box_max_x == o_kept_x && o_box_min_y == o_kept_y && o_box_max_z == o_kept_z, "first point box mismatch")

    `TRPD_ASSERT(a_kept_in_box, o_out_valid |-> o_box_min_x <= o_kept_x && o_kept_x <= o_box_max_x && o_box_min_y <= o_kept_y && o_kept_y <= o_box_max_y && o_box_min_z <= o_kept_z && o_kept_z <= o_box_max_z, "kept point outside box")

endmodule

bind trajectory_point_decimator_top trpd_port_checker #(.COORD_WIDTH(COORD_WIDTH)) u_trpd_checker (.*);
